>>> design/afr_pkg.sv
`default_nettype none

package afr_pkg;

  // Largest payload index that is forwarded, plus one; also the length ceiling.
  localparam int PAYLOAD_MAX = 32;

  localparam int CfgIdxW = 2;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SYNC_BYTE   = 2'd0,
    CFG_OWN_ADDRESS = 2'd1,
    CFG_IDLE_LIMIT  = 2'd2
  } cfg_index_e;

  typedef enum logic [2:0] {
    PH_SYNC = 3'd0,
    PH_ADDR = 3'd1,
    PH_CMD  = 3'd2,
    PH_LEN  = 3'd3,
    PH_DATA = 3'd4,
    PH_CRCH = 3'd5,
    PH_CRCL = 3'd6
  } phase_e;

  typedef enum logic {
    CMD_BYTE = 1'b0,
    CMD_TICK = 1'b1
  } command_e;

  typedef enum logic [1:0] {
    KIND_PAYLOAD   = 2'd0,
    KIND_GOOD      = 2'd1,
    KIND_CRC_ERROR = 2'd2,
    KIND_TIMEOUT   = 2'd3
  } kind_e;

  typedef struct packed {
    logic       command;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] payload_byte;
    logic [7:0] payload_index;
    logic [7:0] frame_command;
    logic [7:0] frame_length;
    logic       address_match;
  } result_t;

  typedef struct packed {
    logic [7:0] sync_byte;
    logic [7:0] own_address;
    logic [7:0] idle_tick_limit;
  } cfg_t;

  // CRC-16/XMODEM update by one byte, MSB first.
  function automatic logic [15:0] crc16_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] r;
    r = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (r[15]) begin
        r = {r[14:0], 1'b0} ^ 16'h1021;
      end else begin
        r = {r[14:0], 1'b0};
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> design/afr_in_stage.sv
`default_nettype none

module afr_in_stage
  import afr_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  output logic       in_ready_o,
  input  wire item_t item_i,
  input  wire logic  advance_i,
  output logic       valid_o,
  output item_t      item_o
);

  logic  valid_q;
  item_t item_q;

  // A new transaction is taken when the stage is empty or drains this cycle.
  assign in_ready_o = !valid_q || advance_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

>>> design/afr_core.sv
`default_nettype none

module afr_core
  import afr_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire cfg_t  cfg_i,
  input  wire logic  item_valid_i,
  input  wire item_t item_i,
  input  wire logic  advance_i,
  output logic       res_valid_o,
  output result_t    res_o
);

  phase_e      phase_q, phase_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  cmd_q, cmd_d;
  logic [7:0]  decl_len_q, decl_len_d;
  logic [7:0]  rcvd_q, rcvd_d;
  logic        addr_ok_q, addr_ok_d;
  logic [7:0]  crc_hi_q, crc_hi_d;
  logic [7:0]  idle_q, idle_d;

  logic [15:0] crc_next;
  logic [7:0]  idle_inc;
  logic [7:0]  rcvd_inc;
  logic [7:0]  b;
  logic        res_valid;
  result_t     res;

  assign b        = item_i.rx_byte;
  assign crc_next = crc16_feed(crc_q, b);
  assign idle_inc = idle_q + 8'd1;
  assign rcvd_inc = rcvd_q + 8'd1;

  always_comb begin
    phase_d    = phase_q;
    crc_d      = crc_q;
    cmd_d      = cmd_q;
    decl_len_d = decl_len_q;
    rcvd_d     = rcvd_q;
    addr_ok_d  = addr_ok_q;
    crc_hi_d   = crc_hi_q;
    idle_d     = idle_q;
    res_valid  = 1'b0;
    res        = '0;

    if (item_i.command == CMD_TICK) begin
      // Ticks only count once a frame has started.
      if (phase_q != PH_SYNC) begin
        idle_d = idle_inc;
        if (idle_inc >= cfg_i.idle_tick_limit) begin
          phase_d   = PH_SYNC;
          idle_d    = '0;
          res_valid = 1'b1;
          res.kind  = KIND_TIMEOUT;
        end
      end
    end else begin
      case (phase_q)
        PH_SYNC: begin
          if (b == cfg_i.sync_byte) begin
            crc_d   = crc16_feed(16'h0000, b);
            idle_d  = '0;
            phase_d = PH_ADDR;
          end
        end
        PH_ADDR: begin
          idle_d    = '0;
          crc_d     = crc_next;
          addr_ok_d = (b == cfg_i.own_address);
          phase_d   = PH_CMD;
        end
        PH_CMD: begin
          idle_d  = '0;
          crc_d   = crc_next;
          cmd_d   = b;
          phase_d = PH_LEN;
        end
        PH_LEN: begin
          idle_d     = '0;
          crc_d      = crc_next;
          decl_len_d = b;
          rcvd_d     = '0;
          phase_d    = (b == 8'd0) ? PH_CRCH : PH_DATA;
        end
        PH_DATA: begin
          idle_d = '0;
          crc_d  = crc_next;
          if (rcvd_q < 8'(PAYLOAD_MAX)) begin
            res_valid         = 1'b1;
            res.kind          = KIND_PAYLOAD;
            res.payload_byte  = b;
            res.payload_index = rcvd_q;
          end
          rcvd_d = rcvd_inc;
          if (rcvd_inc >= decl_len_q) begin
            phase_d = PH_CRCH;
          end
        end
        PH_CRCH: begin
          idle_d   = '0;
          crc_hi_d = b;
          phase_d  = PH_CRCL;
        end
        PH_CRCL: begin
          idle_d            = '0;
          phase_d           = PH_SYNC;
          res_valid         = 1'b1;
          res.kind          = ((crc_hi_q == crc_q[15:8]) && (b == crc_q[7:0])) ?
                              KIND_GOOD : KIND_CRC_ERROR;
          res.frame_command = cmd_q;
          res.frame_length  = (rcvd_q > 8'(PAYLOAD_MAX)) ? 8'(PAYLOAD_MAX) : rcvd_q;
          res.address_match = addr_ok_q;
        end
        default: begin
          phase_d = PH_SYNC;
          idle_d  = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_SYNC;
      crc_q      <= '0;
      cmd_q      <= '0;
      decl_len_q <= '0;
      rcvd_q     <= '0;
      addr_ok_q  <= 1'b0;
      crc_hi_q   <= '0;
      idle_q     <= '0;
    end else if (advance_i) begin
      phase_q    <= phase_d;
      crc_q      <= crc_d;
      cmd_q      <= cmd_d;
      decl_len_q <= decl_len_d;
      rcvd_q     <= rcvd_d;
      addr_ok_q  <= addr_ok_d;
      crc_hi_q   <= crc_hi_d;
      idle_q     <= idle_d;
    end
  end

  assign res_valid_o = item_valid_i && res_valid;
  assign res_o       = res;

endmodule

`default_nettype wire

>>> design/afr_out_stage.sv
`default_nettype none

module afr_out_stage
  import afr_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    load_i,
  input  wire result_t res_i,
  output logic         space_o,
  output logic         out_valid_o,
  input  wire logic    out_ready_i,
  output result_t      res_o
);

  logic    valid_q;
  result_t res_q;

  // The register can take a result when empty or when its transaction completes now.
  assign space_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (space_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (space_o && load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

>>> design/addressed_frame_receiver_crc16.sv
// Channel  | Handshake                 | Payload
// ---------+---------------------------+----------------------------------------------
// input    | in_valid_i / in_ready_o   | command_i, rx_byte_i
// result   | out_valid_o / out_ready_i | kind_o, payload_byte_o, payload_index_o,
//          |                           | frame_command_o, frame_length_o, address_match_o
// config   | cfg_we_i                  | cfg_index_i, cfg_data_i
//
// One transaction per cycle is accepted unless the held item stalls; an item is held in
// the input register, and its result, if any, is then loaded into the result register.
// The input and result registers lie around the parser step, which is combinational.
// Reset returns the parser to waiting for sync and restores register defaults.
// A stalled result register holds back the parser only when the pending item has a result.
`default_nettype none

module addressed_frame_receiver_crc16
  import afr_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic                command_i,
  input  wire logic [7:0]          rx_byte_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic [1:0]               kind_o,
  output logic [7:0]               payload_byte_o,
  output logic [7:0]               payload_index_o,
  output logic [7:0]               frame_command_o,
  output logic [7:0]               frame_length_o,
  output logic                     address_match_o,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [7:0]          cfg_data_i
);

  cfg_t    cfg_q;
  item_t   in_item;
  item_t   stage_item;
  logic    stage_valid;
  logic    res_valid;
  result_t res;
  result_t out_res;
  logic    out_space;
  logic    advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sync_byte       <= 8'd0;
      cfg_q.own_address     <= 8'd1;
      cfg_q.idle_tick_limit <= 8'd1;
    end else if (cfg_we_i) begin
      case (cfg_index_e'(cfg_index_i))
        CFG_SYNC_BYTE:   cfg_q.sync_byte       <= cfg_data_i;
        CFG_OWN_ADDRESS: cfg_q.own_address     <= cfg_data_i;
        CFG_IDLE_LIMIT:  cfg_q.idle_tick_limit <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_item.command = command_i;
  assign in_item.rx_byte = rx_byte_i;

  // The held item moves on unless it has a result and the result register is full.
  assign advance = stage_valid && (!res_valid || out_space);

  afr_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .item_i     (in_item),
    .advance_i  (advance),
    .valid_o    (stage_valid),
    .item_o     (stage_item)
  );

  afr_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_valid_i (stage_valid),
    .item_i       (stage_item),
    .advance_i    (advance),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  afr_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance && res_valid),
    .res_i       (res),
    .space_o     (out_space),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (out_res)
  );

  assign kind_o          = out_res.kind;
  assign payload_byte_o  = out_res.payload_byte;
  assign payload_index_o = out_res.payload_index;
  assign frame_command_o = out_res.frame_command;
  assign frame_length_o  = out_res.frame_length;
  assign address_match_o = out_res.address_match;

`ifndef ASSERT_OFF
  a_timeout_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == KIND_TIMEOUT) |->
      (payload_byte_o == 8'd0) && (payload_index_o == 8'd0) &&
      (frame_command_o == 8'd0) && (frame_length_o == 8'd0) && !address_match_o)
    else $error("timeout result carries nonzero fields");

  a_payload_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == KIND_PAYLOAD) |->
      (payload_index_o < 8'(PAYLOAD_MAX)) && (frame_length_o == 8'd0))
    else $error("payload result index beyond buffer");

  a_frame_length_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ((kind_o == KIND_GOOD) || (kind_o == KIND_CRC_ERROR)) |->
      (frame_length_o <= 8'(PAYLOAD_MAX)))
    else $error("frame length not saturated");

  a_stall_holds_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stage_valid && !advance |=> stage_valid && $stable(stage_item))
    else $error("held item lost while result register full");
`endif

endmodule

`default_nettype wire

>>> dv/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import afr_pkg::*;

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid;
  logic             in_ready;
  command_e         in_command;
  logic [7:0]       in_byte;
  logic             out_valid;
  logic             out_ready;
  logic [1:0]       kind;
  logic [7:0]       payload_byte;
  logic [7:0]       payload_index;
  logic [7:0]       frame_command;
  logic [7:0]       frame_length;
  logic             address_match;
  logic             cfg_we;
  cfg_index_e       cfg_index;
  logic [7:0]       cfg_data;

  addressed_frame_receiver_crc16 dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .command_i       (in_command),
    .rx_byte_i       (in_byte),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .kind_o          (kind),
    .payload_byte_o  (payload_byte),
    .payload_index_o (payload_index),
    .frame_command_o (frame_command),
    .frame_length_o  (frame_length),
    .address_match_o (address_match),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  // Register copies and parser state of the frame predictor.
  logic [7:0]  cfg_sync  = 8'h00;
  logic [7:0]  cfg_addr  = 8'h01;
  logic [7:0]  cfg_limit = 8'h01;
  phase_e      parse_phase  = PH_SYNC;
  logic [15:0] run_crc      = 16'h0000;
  logic [7:0]  cmd_held     = 8'h00;
  logic [7:0]  len_declared = 8'h00;
  logic [7:0]  rcv_count    = 8'h00;
  logic        addr_hit     = 1'b0;
  logic [7:0]  crc_hi_held  = 8'h00;
  logic [7:0]  idle_count   = 8'h00;

  result_t reports_due[$];
  int      mismatches = 0;
  int      items_sent = 0;
  bit      send_idle  = 1'b1;
  bit      recv_idle  = 1'b1;

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // Bit-serial form of the XMODEM polynomial, message bit entering at the top.
  function automatic logic [15:0] crc16_xmodem_byte(input logic [15:0] c, input logic [7:0] b);
    logic fb;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ b[i];
      c  = {c[14:0], 1'b0} ^ (fb ? 16'h1021 : 16'h0000);
    end
    return c;
  endfunction

  function automatic void parse_event(input command_e cmd, input logic [7:0] b);
    result_t    r;
    logic [7:0] idx;
    logic       good;
    r = '0;
    if (cmd == CMD_TICK) begin
      if (parse_phase != PH_SYNC) begin
        idle_count = idle_count + 8'd1;
        if (idle_count >= cfg_limit) begin
          parse_phase = PH_SYNC;
          idle_count  = 8'h00;
          r.kind      = KIND_TIMEOUT;
          reports_due.push_back(r);
        end
      end
    end else begin
      case (parse_phase)
        PH_SYNC: begin
          if (b == cfg_sync) begin
            run_crc     = crc16_xmodem_byte(16'h0000, b);
            idle_count  = 8'h00;
            parse_phase = PH_ADDR;
          end
        end
        PH_ADDR: begin
          idle_count  = 8'h00;
          run_crc     = crc16_xmodem_byte(run_crc, b);
          addr_hit    = (b == cfg_addr);
          parse_phase = PH_CMD;
        end
        PH_CMD: begin
          idle_count  = 8'h00;
          run_crc     = crc16_xmodem_byte(run_crc, b);
          cmd_held    = b;
          parse_phase = PH_LEN;
        end
        PH_LEN: begin
          idle_count   = 8'h00;
          run_crc      = crc16_xmodem_byte(run_crc, b);
          len_declared = b;
          rcv_count    = 8'h00;
          parse_phase  = (b == 8'h00) ? PH_CRCH : PH_DATA;
        end
        PH_DATA: begin
          idx        = rcv_count;
          idle_count = 8'h00;
          run_crc    = crc16_xmodem_byte(run_crc, b);
          if (idx < PAYLOAD_MAX) begin
            r.kind          = KIND_PAYLOAD;
            r.payload_byte  = b;
            r.payload_index = idx;
            reports_due.push_back(r);
          end
          rcv_count = idx + 8'd1;
          if (rcv_count >= len_declared) parse_phase = PH_CRCH;
        end
        PH_CRCH: begin
          idle_count  = 8'h00;
          crc_hi_held = b;
          parse_phase = PH_CRCL;
        end
        PH_CRCL: begin
          good = (crc_hi_held == run_crc[15:8]) && (b == run_crc[7:0]);
          r.kind          = good ? KIND_GOOD : KIND_CRC_ERROR;
          r.frame_command = cmd_held;
          r.frame_length  = (rcv_count > PAYLOAD_MAX) ? 8'(PAYLOAD_MAX) : rcv_count;
          r.address_match = addr_hit;
          idle_count  = 8'h00;
          parse_phase = PH_SYNC;
          reports_due.push_back(r);
        end
        default: begin
          parse_phase = PH_SYNC;
          idle_count  = 8'h00;
        end
      endcase
    end
  endfunction

  task automatic send_event(input command_e cmd, input logic [7:0] b);
    int gap;
    gap = send_idle ? $urandom_range(0, 17) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid   = 1'b1;
    in_command = cmd;
    in_byte    = b;
    do @(posedge clk_i); while (!in_ready);
    items_sent++;
    parse_event(cmd, b);
  endtask

  // Sends a frame built with the current sync byte. A negative fill gives a random
  // payload; keep, when not negative, cuts the frame after that many bytes.
  task automatic send_frame(input logic [7:0] addr, input logic [7:0] op, input logic [7:0] len,
                            input int fill, input bit bad_crc, input bit quiet_ticks,
                            input int keep);
    logic [7:0]  frame_bytes[$];
    logic [15:0] sum;
    int          limit_eff;
    int          n_ticks;
    frame_bytes = {cfg_sync, addr, op, len};
    for (int i = 0; i < len; i++) begin
      frame_bytes.push_back((fill < 0) ? 8'($urandom) : 8'(fill));
    end
    sum = 16'h0000;
    foreach (frame_bytes[i]) sum = crc16_xmodem_byte(sum, frame_bytes[i]);
    if (bad_crc) sum = sum ^ (16'h0001 << $urandom_range(0, 15));
    frame_bytes.push_back(sum[15:8]);
    frame_bytes.push_back(sum[7:0]);
    limit_eff = (cfg_limit == 8'h00) ? 1 : int'(cfg_limit);
    foreach (frame_bytes[i]) begin
      if (keep >= 0 && i >= keep) break;
      // A few ticks short of the limit must not abort the frame.
      if (quiet_ticks && limit_eff > 1 && $urandom_range(0, 5) == 0) begin
        n_ticks = $urandom_range(1, (limit_eff > 4) ? 3 : limit_eff - 1);
        repeat (n_ticks) send_event(CMD_TICK, 8'($urandom));
      end
      send_event(CMD_BYTE, frame_bytes[i]);
    end
  endtask

  task automatic return_to_sync();
    while (parse_phase != PH_SYNC) begin
      if (cfg_limit <= 8'd16) send_event(CMD_TICK, 8'($urandom));
      else send_event(CMD_BYTE, 8'($urandom));
    end
  endtask

  // Holds the sender off until every predicted result has been taken, then lets the
  // pipeline empty of items that produce nothing.
  task automatic wait_for_reports();
    @(negedge clk_i);
    in_valid = 1'b0;
    while (reports_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_index_e idx, input logic [7:0] value);
    @(negedge clk_i);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    @(negedge clk_i);
    cfg_we = 1'b0;
    case (idx)
      CFG_SYNC_BYTE:   cfg_sync  = value;
      CFG_OWN_ADDRESS: cfg_addr  = value;
      CFG_IDLE_LIMIT:  cfg_limit = value;
      default: ;
    endcase
  endtask

  task automatic test_defaults();
    send_idle = 1'b1;
    recv_idle = 1'b1;
    send_event(CMD_TICK, 8'hFF);
    send_event(CMD_BYTE, 8'h55);
    send_frame(cfg_addr, 8'h80, 8'd1, 'hFF, 1'b0, 1'b0, -1);
    wait_for_reports();
  endtask

  task automatic test_special_cases();
    write_reg(CFG_SYNC_BYTE, 8'hFF);
    write_reg(CFG_OWN_ADDRESS, 8'h00);
    write_reg(CFG_IDLE_LIMIT, 8'd1);
    send_frame(8'h00, 8'h00, 8'd0, -1, 1'b0, 1'b0, -1);
    send_frame(8'hFF, 8'hFF, 8'd2, 'h00, 1'b1, 1'b0, -1);
    send_event(CMD_BYTE, cfg_sync);
    send_event(CMD_TICK, 8'h00);
    wait_for_reports();
    // The idle count also runs while the low CRC byte is awaited.
    write_reg(CFG_IDLE_LIMIT, 8'd2);
    send_frame(8'h00, 8'h5A, 8'd0, -1, 1'b0, 1'b0, 5);
    send_event(CMD_TICK, 8'h00);
    send_event(CMD_TICK, 8'hFF);
    wait_for_reports();
    write_reg(CFG_IDLE_LIMIT, 8'd0);
    send_event(CMD_BYTE, cfg_sync);
    send_event(CMD_TICK, 8'h3C);
    wait_for_reports();
  endtask

  task automatic test_random_traffic(input logic [7:0] sync_v, input logic [7:0] addr_v,
                                     input logic [7:0] limit_v, input int n_items);
    int         stop_at;
    int         pick;
    int         len;
    bit         first;
    logic [7:0] addr;
    wait_for_reports();
    write_reg(CFG_SYNC_BYTE, sync_v);
    write_reg(CFG_OWN_ADDRESS, addr_v);
    write_reg(CFG_IDLE_LIMIT, limit_v);
    send_idle = ($urandom_range(0, 3) != 0);
    recv_idle = ($urandom_range(0, 3) != 0);
    stop_at = items_sent + n_items;
    first = 1'b1;
    while (items_sent < stop_at) begin
      if ($urandom_range(0, 19) == 0) send_idle = !send_idle;
      if ($urandom_range(0, 19) == 0) recv_idle = !recv_idle;
      addr = $urandom_range(0, 1) ? cfg_addr : 8'($urandom);
      pick = $urandom_range(0, 99);
      len  = $urandom_range(0, 99);
      if (len < 80) len = $urandom_range(0, 6);
      else if (len < 93) len = $urandom_range(7, PAYLOAD_MAX);
      else len = $urandom_range(PAYLOAD_MAX + 1, PAYLOAD_MAX + 8);
      if (first) len = PAYLOAD_MAX + 2;
      if (pick < 72) begin
        send_frame(addr, 8'($urandom), 8'(len), -1, $urandom_range(0, 4) == 0,
                   $urandom_range(0, 1) == 1, -1);
      end else if (pick < 87) begin
        send_frame(addr, 8'($urandom), 8'(len), -1, 1'b0, 1'b1, $urandom_range(1, len + 5));
        return_to_sync();
      end else begin
        repeat ($urandom_range(1, 6)) begin
          if ($urandom_range(0, 2) == 0) send_event(CMD_TICK, 8'($urandom));
          else if ($urandom_range(0, 2) == 0) send_event(CMD_BYTE, cfg_sync);
          else send_event(CMD_BYTE, 8'($urandom));
        end
        return_to_sync();
      end
      first = 1'b0;
    end
  endtask

  initial begin : report_checker
    result_t want;
    int      stall;
    out_ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = recv_idle ? $urandom_range(0, 17) : 0;
      @(negedge clk_i);
      if (stall > 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready = 1'b1;
      do @(posedge clk_i); while (!out_valid);
      if (reports_due.size() == 0) begin
        $error("unexpected result transaction: kind %0d", kind);
        mismatches++;
      end else begin
        want = reports_due.pop_front();
        if (kind !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, kind);
          mismatches++;
        end
        if (payload_byte !== want.payload_byte) begin
          $error("payload_byte: expected 0x%0h, got 0x%0h", want.payload_byte, payload_byte);
          mismatches++;
        end
        if (payload_index !== want.payload_index) begin
          $error("payload_index: expected %0d, got %0d", want.payload_index, payload_index);
          mismatches++;
        end
        if (frame_command !== want.frame_command) begin
          $error("frame_command: expected 0x%0h, got 0x%0h", want.frame_command,
                 frame_command);
          mismatches++;
        end
        if (frame_length !== want.frame_length) begin
          $error("frame_length: expected %0d, got %0d", want.frame_length, frame_length);
          mismatches++;
        end
        if (address_match !== want.address_match) begin
          $error("address_match: expected %0d, got %0d", want.address_match, address_match);
          mismatches++;
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("** addressed_frame_receiver_crc16: FAILED **");
    $finish;
  end

  initial begin
    in_valid   = 1'b0;
    in_command = CMD_BYTE;
    in_byte    = 8'h00;
    cfg_we     = 1'b0;
    cfg_index  = CFG_SYNC_BYTE;
    cfg_data   = 8'h00;
    rst_ni     = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_defaults();
    test_special_cases();
    test_random_traffic(8'h00, 8'h00, 8'd1, 150);
    test_random_traffic(8'hFF, 8'hFF, 8'd255, 120);
    test_random_traffic(8'($urandom), 8'($urandom), 8'($urandom_range(2, 12)), 160);
    test_random_traffic(8'h7E, 8'($urandom), 8'd0, 80);
    test_random_traffic(8'($urandom), 8'($urandom), 8'($urandom_range(1, 20)), 240);

    wait_for_reports();
    repeat (40) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("** addressed_frame_receiver_crc16: PASSED **");
    end else begin
      $display("** addressed_frame_receiver_crc16: FAILED **");
    end
    $finish;
  end

endmodule
